>>> rtl/qmips_pkg.sv
// Shared field widths, operation codes and controller/datapath handshake types.
package qmips_pkg;

   localparam int OP_W     = 2;
   localparam int DIM_W    = 9;
   localparam int QV_W     = 16;
   localparam int CODE_W   = 8;
   localparam int AMP_W    = 16;
   localparam int SCORE_W  = 48;
   localparam int ADDRN_W  = 16;
   localparam int DOT_W    = 32;
   localparam int WEIGHT_W = CODE_W + 1;
   localparam int PROD_W   = WEIGHT_W + QV_W;

   localparam logic [CODE_W-1:0] CODE_OFFSET = 8'd127;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_CODE  = 2'd1;
   localparam logic [OP_W-1:0] OP_EMPTY = 2'd2;

   typedef struct packed {
      logic mac;
      logic scale;
      logic update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_rec;
      logic last_addr;
      logic out_free;
   } sts_type;

endpackage

>>> rtl/qmips_if.sv
// Request and response channel interfaces with valid/ready handshake.
interface qmips_req_if import qmips_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic [DIM_W-1:0]        dim_index;
   logic signed [QV_W-1:0]  query_value;
   logic [CODE_W-1:0]       code;
   logic [AMP_W-1:0]        amplitude;
   logic                    last_in_record;
   logic                    last_in_address;

   modport source (output valid, op, dim_index, query_value, code, amplitude,
                    last_in_record, last_in_address, input ready);
   modport sink   (input valid, op, dim_index, query_value, code, amplitude,
                   last_in_record, last_in_address, output ready);
endinterface

interface qmips_rsp_if import qmips_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SCORE_W-1:0] best_score;
   logic                      empty_res;
   logic [ADDRN_W-1:0]        address_number;

   modport source (output valid, best_score, empty_res, address_number, input ready);
   modport sink   (input valid, best_score, empty_res, address_number, output ready);
endinterface

>>> rtl/qmips_ctrl.sv
// Sequencing state machine that steps each request through the datapath.
module qmips_ctrl import qmips_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [OP_W-1:0] req_op,
   input  sts_type         sts,
   output logic            ready,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_SCALE,
      S_UPDATE,
      S_EMIT
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_op == OP_CODE) begin
                     state_ff <= S_MAC;
                  end else if (req_op == OP_EMPTY) begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_MAC:    state_ff <= sts.last_rec ? S_SCALE : S_IDLE;
            S_SCALE:  state_ff <= S_UPDATE;
            S_UPDATE: state_ff <= sts.last_addr ? S_EMIT : S_IDLE;
            S_EMIT: begin
               if (sts.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   assign ready      = (state_ff == S_IDLE);
   assign cmd.mac    = (state_ff == S_MAC);
   assign cmd.scale  = (state_ff == S_SCALE);
   assign cmd.update = (state_ff == S_UPDATE);
   assign cmd.emit   = (state_ff == S_EMIT) && sts.out_free;

endmodule

>>> rtl/qmips_dp.sv
// Query memory, multiply-accumulate, amplitude scaling, maximum tracking and result register.
module qmips_dp import qmips_pkg::*; #(
   parameter int DIMENSIONS    = 384,
   parameter int MAX_ADDRESSES = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [OP_W-1:0]           op,
   input  logic [DIM_W-1:0]          dim_index,
   input  logic signed [QV_W-1:0]    query_value,
   input  logic [CODE_W-1:0]         code,
   input  logic [AMP_W-1:0]          amplitude,
   input  logic                      last_in_record,
   input  logic                      last_in_address,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SCORE_W-1:0] best_score,
   output logic                      empty_res,
   output logic [ADDRN_W-1:0]        address_number
);

   localparam int ADDR_W = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
   localparam int CNT_W  = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1;

   logic [QV_W-1:0] query_mem [DIMENSIONS];

   logic [ADDR_W+DIM_W-1:0]   idx_ext;
   logic [ADDR_W-1:0]         mem_addr;
   logic                      in_rng;

   logic signed [QV_W-1:0]    q_rd_ff;
   logic [CODE_W-1:0]         code_ff;
   logic [AMP_W-1:0]          amp_ff;
   logic                      in_rng_ff;
   logic                      last_rec_ff;
   logic                      last_addr_ff;

   logic signed [DOT_W-1:0]   dot_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic signed [SCORE_W-1:0] max_ff;
   logic                      have_max_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [CNT_W+ADDRN_W-1:0]  cnt_ext;

   logic                      rsp_valid_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   logic                      rsp_empty_ff;
   logic [ADDRN_W-1:0]        rsp_addr_ff;

   logic signed [WEIGHT_W-1:0] weight;
   logic signed [PROD_W-1:0]   prod;
   logic signed [DOT_W-1:0]    dot_in;
   logic signed [SCORE_W:0]    scaled;
   logic                       out_free;

   assign idx_ext  = {{ADDR_W{1'b0}}, dim_index};
   assign mem_addr = idx_ext[ADDR_W-1:0];
   assign in_rng   = (32'(dim_index) < DIMENSIONS);

   // Query memory: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (accept && (op == OP_LOAD) && in_rng) begin
         query_mem[mem_addr] <= query_value;
      end
      q_rd_ff <= query_mem[mem_addr];
   end

   // Per-request payload capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff   <= code;
         amp_ff    <= amplitude;
         in_rng_ff <= in_rng;
      end
   end

   assign weight = $signed({1'b0, code_ff}) - $signed({1'b0, CODE_OFFSET});
   assign prod   = weight * q_rd_ff;
   assign dot_in = dot_ff + (in_rng_ff ? DOT_W'(prod) : DOT_W'(0));
   assign scaled = dot_ff * $signed({1'b0, amp_ff});

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cnt_ext  = {{ADDRN_W{1'b0}}, cnt_ff};

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         score_ff <= scaled[SCORE_W-1:0];
      end
      if (cmd.emit) begin
         rsp_score_ff <= have_max_ff ? max_ff : SCORE_W'(0);
         rsp_empty_ff <= !have_max_ff;
         rsp_addr_ff  <= cnt_ext[ADDRN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_rec_ff  <= 1'b0;
         last_addr_ff <= 1'b0;
         dot_ff       <= '0;
         max_ff       <= '0;
         have_max_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            last_rec_ff  <= last_in_record;
            last_addr_ff <= last_in_address;
         end
         priority if (accept && (op == OP_LOAD)) begin
            // A query load restarts the address scan.
            dot_ff      <= '0;
            max_ff      <= '0;
            have_max_ff <= 1'b0;
            cnt_ff      <= '0;
         end else if (cmd.mac) begin
            dot_ff <= dot_in;
         end else if (cmd.scale) begin
            dot_ff <= '0;
         end else if (cmd.update) begin
            if (!have_max_ff || (score_ff > max_ff)) begin
               max_ff      <= score_ff;
               have_max_ff <= 1'b1;
            end
         end else if (cmd.emit) begin
            dot_ff      <= '0;
            max_ff      <= '0;
            have_max_ff <= 1'b0;
            cnt_ff      <= (cnt_ff == CNT_W'(MAX_ADDRESSES - 1)) ? '0 : cnt_ff + 1'b1;
         end else begin
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.last_rec  = last_rec_ff;
   assign sts.last_addr = last_addr_ff;
   assign sts.out_free  = out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign best_score     = rsp_score_ff;
   assign empty_res      = rsp_empty_ff;
   assign address_number = rsp_addr_ff;

endmodule

>>> rtl/quantized_max_inner_product_score_top.sv
// Top level of the quantized max-inner-product scorer: controller, datapath and assertions.
// Per request: query load and unused op are handled at acceptance; a code byte that does
// not end a record gets a query memory read, then multiply-accumulate; a record's last
// byte adds amplitude scale and max update, then emit if it ends the address; empty-address
// goes to emit. Emitting waits while the result register still holds an untaken response.
// Reset is synchronous and active high; it clears sums, maximum, counter and response valid.
module quantized_max_inner_product_score_top import qmips_pkg::*; #(
   parameter int DIMENSIONS    = 384,
   parameter int MAX_ADDRESSES = 65536
) (
   input  logic       clock,
   input  logic       reset,
   qmips_req_if.sink  req,
   qmips_rsp_if.source rsp
);

   // The controller admits one request at a time; the datapath holds a single
   // query memory read port and the multiply-accumulate and amplitude scale multipliers.
   logic    accept;
   logic    ready;
   cmd_type cmd;
   sts_type sts;

   assign accept    = req.valid && ready;
   assign req.ready = ready;

   qmips_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req_op (req.op),
      .sts    (sts),
      .ready  (ready),
      .cmd    (cmd)
   );

   // The datapath accumulates each record's dot sum, scales it by the
   // amplitude and keeps the address maximum until the address closes.
   qmips_dp #(
      .DIMENSIONS    (DIMENSIONS),
      .MAX_ADDRESSES (MAX_ADDRESSES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .op              (req.op),
      .dim_index       (req.dim_index),
      .query_value     (req.query_value),
      .code            (req.code),
      .amplitude       (req.amplitude),
      .last_in_record  (req.last_in_record),
      .last_in_address (req.last_in_address),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .best_score      (rsp.best_score),
      .empty_res       (rsp.empty_res),
      .address_number  (rsp.address_number)
   );

   // An empty address always reports a zero score.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.empty_res |-> rsp.best_score == '0)
      else $error("empty result with nonzero score");

   // A query load finishes in the cycle it is accepted.
   a_load_single: assert property (@(posedge clock) disable iff (reset)
      accept && (req.op == OP_LOAD) |=> ready)
      else $error("query load did not complete in one cycle");

   // A code byte always occupies the multiply-accumulate cycle after acceptance.
   a_code_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req.op == OP_CODE) |=> !ready && cmd.mac)
      else $error("code byte did not enter multiply-accumulate");

   // A result is only loaded when the response register is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp.valid || rsp.ready)
      else $error("response overwritten before it was taken");

endmodule

>>> dv/tb_quantized_max_inner_product_score_top.sv
// Testbench for the quantized max-inner-product scorer: directed and random requests, scoreboard.
`timescale 1ns / 1ps
module tb_quantized_max_inner_product_score_top;
   import qmips_pkg::*;

   // The query memory depth matches the DIMENSIONS parameter given to the block.
   localparam int QUERY_DEPTH       = 384;
   localparam int ADDRESS_WRAP      = 65536;
   localparam int INDEX_SPAN        = 511;
   // The package names no code for the fourth operation, which the block ignores.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_REQUESTS   = 600;
   localparam int HOLD_OFF_CYCLES   = 300;
   localparam int DRAIN_CYCLES      = 20;
   localparam int CYCLE_LIMIT       = 400000;

   typedef struct {
      logic [OP_W-1:0]        op;
      logic [DIM_W-1:0]       dim_index;
      logic signed [QV_W-1:0] query_value;
      logic [CODE_W-1:0]      code;
      logic [AMP_W-1:0]       amplitude;
      logic                   last_in_record;
      logic                   last_in_address;
   } request_type;

   typedef struct {
      logic signed [SCORE_W-1:0] best_score;
      logic                      empty_res;
      logic [ADDRN_W-1:0]        address_number;
   } score_type;

   // The scoreboard keeps its own copy of the query vector, the running dot product, the
   // best record score of the open address and the address counter. Every accepted request
   // goes through absorb_request, which queues the score that the request must produce.
   class address_max_scoreboard;
      logic [QV_W-1:0]  query_mem [QUERY_DEPTH];
      logic [DOT_W-1:0] dot_acc;
      longint           best;
      bit               holding;
      int               address_seq;
      score_type        awaited_scores [$];
      int               mismatches;
      int               scores_predicted;
      int               scores_checked;
      int               empties_checked;

      function new();
         foreach (query_mem[i]) query_mem[i] = '0;
         restart_scan();
         mismatches = 0;
         scores_predicted = 0;
         scores_checked = 0;
         empties_checked = 0;
      endfunction

      function void restart_scan();
         address_seq = 0;
         dot_acc = '0;
         best = 0;
         holding = 1'b0;
      endfunction

      function void close_address(bit empty);
         score_type s;
         s.best_score = empty ? '0 : best[SCORE_W-1:0];
         s.empty_res = empty;
         s.address_number = address_seq[ADDRN_W-1:0];
         awaited_scores.insert(awaited_scores.size(), s);
         scores_predicted++;
         address_seq = (address_seq + 1 >= ADDRESS_WRAP) ? 0 : address_seq + 1;
         dot_acc = '0;
         best = 0;
         holding = 1'b0;
      endfunction

      function void absorb_request(request_type r);
         longint weight;
         longint product;
         longint score;
         case (r.op)
            OP_LOAD: begin
               if (r.dim_index < QUERY_DEPTH) query_mem[r.dim_index] = r.query_value;
               restart_scan();
            end
            OP_EMPTY: close_address(!holding);
            OP_CODE: begin
               // Bytes beyond the vector add nothing, but their end marks still count.
               if (r.dim_index < QUERY_DEPTH) begin
                  weight = longint'(r.code) - longint'(CODE_OFFSET);
                  product = weight * longint'($signed(query_mem[r.dim_index]));
                  dot_acc = dot_acc + product[DOT_W-1:0];
               end
               if (r.last_in_record) begin
                  score = longint'($signed(dot_acc)) * longint'(r.amplitude);
                  if (!holding || score > best) begin
                     best = score;
                     holding = 1'b1;
                  end
                  dot_acc = '0;
                  if (r.last_in_address) close_address(1'b0);
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_score(score_type got);
         score_type want;
         if (awaited_scores.size() == 0) begin
            $error("Response with no request awaiting it: best_score %0d, empty_res %0b, %s %0d",
                   got.best_score, got.empty_res, "address_number", got.address_number);
            mismatches++;
            return;
         end
         want = awaited_scores.pop_front();
         if (got.best_score !== want.best_score) begin
            $error("best_score: expected %0d, actual %0d", want.best_score, got.best_score);
            mismatches++;
         end
         if (got.empty_res !== want.empty_res) begin
            $error("empty_res: expected %0b, actual %0b", want.empty_res, got.empty_res);
            mismatches++;
         end
         if (got.address_number !== want.address_number) begin
            $error("address_number: expected %0d, actual %0d",
                   want.address_number, got.address_number);
            mismatches++;
         end
         scores_checked++;
         if (want.empty_res) empties_checked++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   qmips_req_if req_bus ();
   qmips_rsp_if rsp_bus ();

   quantized_max_inner_product_score_top #(
      .DIMENSIONS    (QUERY_DEPTH),
      .MAX_ADDRESSES (ADDRESS_WRAP)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   address_max_scoreboard board;

   // Query positions that have been written. A code byte only ever points at one of these
   // or past the end of the vector, so the block never reads an unwritten query element.
   bit loaded [QUERY_DEPTH];
   int loaded_list [$];

   int requests_sent = 0;
   int loads_sent    = 0;
   int cycle_count   = 0;
   int stall_left    = 0;

   // calm removes the random gaps and stalls on both sides for a stretch; rush only the sender's
   // gaps, used while the receiver holds off so that the block backs up into its request port.
   bit calm = 1'b0;
   bit rush = 1'b0;
   bit hold_off_pending = 1'b0;

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver. It checks every response taken at this edge and then picks the ready level
   // for the next cycle. Most stalls are short, a few are long, and a hold-off requested by
   // the stimulus holds ready low while stall_left, loaded from HOLD_OFF_CYCLES, counts down.
   always @(posedge clock) begin : receiver
      score_type got;
      int roll;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.best_score = rsp_bus.best_score;
            got.empty_res = rsp_bus.empty_res;
            got.address_number = rsp_bus.address_number;
            board.compare_score(got);
         end
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && !calm) begin
            roll = $urandom_range(99);
            if (roll < 70) stall_left = 0;
            else if (roll < 92) stall_left = $urandom_range(3, 1);
            else if (roll < 99) stall_left = $urandom_range(12, 4);
            else stall_left = $urandom_range(40, 20);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      if (calm || rush) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic logic signed [QV_W-1:0] pick_query_value();
      case ($urandom_range(19))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return QV_W'($urandom);
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] pick_code();
      case ($urandom_range(19))
         0: return 8'd0;
         1: return 8'd255;
         2: return CODE_OFFSET;
         default: return CODE_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [AMP_W-1:0] pick_amplitude();
      case ($urandom_range(19))
         0: return 16'd0;
         1: return 16'hffff;
         default: return AMP_W'($urandom_range(65535));
      endcase
   endfunction

   // A code position: mostly one already loaded, otherwise one past the end of the vector.
   function automatic logic [DIM_W-1:0] pick_index();
      if (loaded_list.size() > 0 && $urandom_range(99) < 90)
         return DIM_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
      return DIM_W'($urandom_range(INDEX_SPAN, QUERY_DEPTH));
   endfunction

   function automatic request_type random_fields(logic [OP_W-1:0] op);
      request_type r;
      r.op = op;
      r.dim_index = DIM_W'($urandom_range(INDEX_SPAN));
      r.query_value = pick_query_value();
      r.code = pick_code();
      r.amplitude = pick_amplitude();
      r.last_in_record = 1'($urandom_range(1));
      r.last_in_address = 1'($urandom_range(1));
      return r;
   endfunction

   function automatic request_type make_request(logic [OP_W-1:0] op, int dim,
                                                logic signed [QV_W-1:0] value,
                                                logic [CODE_W-1:0] code, logic [AMP_W-1:0] amp,
                                                logic end_record, logic end_address);
      request_type r;
      r.op = op;
      r.dim_index = DIM_W'(dim);
      r.query_value = value;
      r.code = code;
      r.amplitude = amp;
      r.last_in_record = end_record;
      r.last_in_address = end_address;
      return r;
   endfunction

   // Offers one request, waits for the edge that takes it, then idles for the given gap. With
   // no gap, valid stays high and the next call replaces the payload in the same step.
   task automatic send_request(request_type r, int gap);
      req_bus.valid <= 1'b1;
      req_bus.op <= r.op;
      req_bus.dim_index <= r.dim_index;
      req_bus.query_value <= r.query_value;
      req_bus.code <= r.code;
      req_bus.amplitude <= r.amplitude;
      req_bus.last_in_record <= r.last_in_record;
      req_bus.last_in_address <= r.last_in_address;
      do @(posedge clock); while (!req_bus.ready);
      board.absorb_request(r);
      if (r.op != OP_UNUSED) requests_sent++;
      if (r.op == OP_LOAD) begin
         loads_sent++;
         if (r.dim_index < QUERY_DEPTH && !loaded[r.dim_index]) begin
            loaded[r.dim_index] = 1'b1;
            loaded_list.insert(loaded_list.size(), int'(r.dim_index));
         end
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every queued score has come back. It always waits on a
   // clock edge, so the next request is driven in a later time step.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.awaited_scores.size() != 0);
   endtask

   // One well-formed address: up to three records of random length. Most addresses end on
   // the last byte of their final record; some are closed by an empty-address request with a
   // record score held, and an address with no records is closed the same way.
   task automatic send_address();
      request_type r;
      int records;
      int bytes;
      int i;
      int j;
      bit close_by_empty;
      records = $urandom_range(3, 0);
      close_by_empty = ($urandom_range(99) < 15);
      for (i = 0; i < records; i++) begin
         bytes = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
         for (j = 0; j < bytes; j++) begin
            r = random_fields(OP_CODE);
            r.dim_index = pick_index();
            r.last_in_record = (j == bytes - 1);
            // The address mark is free on inner bytes, where the block must ignore it.
            if (r.last_in_record) r.last_in_address = (i == records - 1) && !close_by_empty;
            send_request(r, pick_gap());
         end
      end
      if (records == 0 || close_by_empty) send_request(random_fields(OP_EMPTY), pick_gap());
   endtask

   // A few query writes. Each one also restarts the address scan.
   task automatic send_query_burst();
      request_type r;
      int count;
      int i;
      count = $urandom_range(8, 1);
      for (i = 0; i < count; i++) begin
         r = random_fields(OP_LOAD);
         if ($urandom_range(99) < 90) r.dim_index = DIM_W'($urandom_range(QUERY_DEPTH - 1));
         else r.dim_index = DIM_W'($urandom_range(INDEX_SPAN, QUERY_DEPTH));
         send_request(r, pick_gap());
      end
   endtask

   // Loose requests of any operation with random marks, which break up address sequences.
   task automatic send_noise();
      request_type r;
      int count;
      int i;
      count = $urandom_range(3, 1);
      for (i = 0; i < count; i++) begin
         r = random_fields(OP_W'($urandom_range(3)));
         if (r.op == OP_CODE) r.dim_index = pick_index();
         send_request(r, pick_gap());
      end
   endtask

   // Directed opening: field extremes, each operation and the corner cases of the scan.
   task automatic send_directed();
      // Extreme query values, a zero, the top position and a write past the end.
      send_request(make_request(OP_LOAD, 0, 16'sh7fff, 8'd0, 16'd0, 1'b0, 1'b0), pick_gap());
      send_request(make_request(OP_LOAD, 1, 16'sh8000, 8'd255, 16'hffff, 1'b1, 1'b1),
                   pick_gap());
      send_request(make_request(OP_LOAD, 2, 16'sh0000, 8'd0, 16'd0, 1'b0, 1'b0), pick_gap());
      send_request(make_request(OP_LOAD, 383, 16'sd1234, 8'd0, 16'd0, 1'b0, 1'b0), pick_gap());
      send_request(make_request(OP_LOAD, 500, 16'sh5a5a, 8'd0, 16'd0, 1'b0, 1'b0), pick_gap());
      // An address with no records scores as empty.
      send_request(make_request(OP_EMPTY, 511, 16'shffff, 8'd255, 16'hffff, 1'b1, 1'b1),
                   pick_gap());
      // The largest positive dot product at full amplitude.
      send_request(make_request(OP_CODE, 0, 16'sd0, 8'd255, 16'd0, 1'b0, 1'b1), pick_gap());
      send_request(make_request(OP_CODE, 1, 16'sd0, 8'd0, 16'hffff, 1'b1, 1'b1), pick_gap());
      // A negative record, an address mark without a record end, a byte past the end of
      // the vector that still closes its record, a partial record, then an empty-address
      // request that reports the held maximum and drops the partial sum.
      send_request(make_request(OP_CODE, 1, 16'sd0, 8'd255, 16'hffff, 1'b1, 1'b0), pick_gap());
      send_request(make_request(OP_CODE, 383, 16'sd0, 8'd0, 16'd0, 1'b0, 1'b1), pick_gap());
      send_request(make_request(OP_CODE, 511, 16'sd0, 8'd77, 16'd4096, 1'b1, 1'b0), pick_gap());
      send_request(make_request(OP_CODE, 0, 16'sd0, 8'd200, 16'd0, 1'b0, 1'b0), pick_gap());
      send_request(make_request(OP_EMPTY, 0, 16'sd0, 8'd0, 16'd0, 1'b0, 1'b0), pick_gap());
      // The unused operation with every field bit set.
      send_request(make_request(OP_UNUSED, 511, 16'shffff, 8'd255, 16'hffff, 1'b1, 1'b1),
                   pick_gap());
      // A zero weight gives a zero score, which still counts as the first maximum.
      send_request(make_request(OP_CODE, 2, 16'sd0, CODE_OFFSET, 16'd0, 1'b1, 1'b1), pick_gap());
      // A query write in the middle of an address discards it and restarts numbering.
      send_request(make_request(OP_CODE, 0, 16'sd0, 8'd1, 16'd1, 1'b1, 1'b0), pick_gap());
      send_request(make_request(OP_LOAD, 3, 16'shffff, 8'd0, 16'd0, 1'b0, 1'b0), pick_gap());
      send_request(make_request(OP_EMPTY, 0, 16'sd0, 8'd0, 16'd0, 1'b0, 1'b0), pick_gap());
      send_request(make_request(OP_CODE, 3, 16'sd0, 8'd128, 16'h8000, 1'b1, 1'b1), pick_gap());
   endtask

   initial begin
      int start_requests;
      bit hold_off_done;
      bit pause_done;

      // Every input of the block is known from time zero.
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_LOAD;
      req_bus.dim_index = '0;
      req_bus.query_value = '0;
      req_bus.code = '0;
      req_bus.amplitude = '0;
      req_bus.last_in_record = 1'b0;
      req_bus.last_in_address = 1'b0;
      rsp_bus.ready = 1'b0;
      board = new();
      hold_off_done = 1'b0;
      pause_done = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_directed();
      drain_results();

      // Random part. It mostly sends well-formed addresses whose bytes point at loaded query
      // positions, mixed with query bursts and loose requests. Once, early on, the receiver
      // holds off while the sender streams addresses back to back; once, later, the sender
      // waits until every outstanding score has come back.
      start_requests = requests_sent;
      while ((requests_sent - start_requests) < RANDOM_REQUESTS) begin
         if (!hold_off_done && (requests_sent - start_requests) >= 150) begin
            hold_off_pending = 1'b1;
            rush = 1'b1;
            repeat (4) send_address();
            rush = 1'b0;
            hold_off_done = 1'b1;
         end else if (!pause_done && (requests_sent - start_requests) >= 350) begin
            drain_results();
            pause_done = 1'b1;
         end else begin
            calm = ($urandom_range(99) < 15);
            case ($urandom_range(99)) inside
               [0:67]:  send_address();
               [68:79]: send_query_burst();
               default: send_noise();
            endcase
            calm = 1'b0;
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests, %0d of them query writes, and %0d checked scores,",
               requests_sent, loads_sent, board.scores_checked);
      $display("%0d of which were empty addresses, with one long receiver hold-off.",
               board.empties_checked);
      if (board.mismatches == 0 && board.awaited_scores.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/qmips_pkg.sv
rtl/qmips_if.sv
rtl/qmips_ctrl.sv
rtl/qmips_dp.sv
rtl/quantized_max_inner_product_score_top.sv
dv/tb_quantized_max_inner_product_score_top.sv
